FILE: rtl/ttwc_pkg.sv
// ----------------------------------------------------------------------------
// ttwc_pkg
// Shared types, constants and character class tables for the width counter.
// ----------------------------------------------------------------------------
package ttwc_pkg;

	localparam int CP_BITS       = 21;
	localparam int OUT_BITS      = 24;
	localparam int SUM_BITS_DEF  = 24;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [CP_BITS-1:0] CP_ZWJ      = 21'h200D;
	localparam logic [CP_BITS-1:0] CP_VS16     = 21'hFE0F;
	localparam logic [CP_BITS-1:0] CP_ESC      = 21'h1B;
	localparam logic [CP_BITS-1:0] CP_LBRACKET = 21'h5B;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_ESC = 2'd1;
	localparam logic [1:0] ST_BAD_CSI = 2'd2;

	// Character kind decided by the front end.
	typedef enum logic [2:0] {
		K_W0, K_W1, K_W2, K_ZWJ, K_VS16, K_ESC
	} kind_t;

	// One classified request passed from front to back.
	typedef struct packed {
		logic [CP_BITS-1:0] cp;
		kind_t              kind;
		logic               vs16_ok;  // code point is in the VS16 widen list
		logic               esc_fin;  // 0x40..0x5F
		logic               csi_fin;  // 0x40..0x7E
		logic               csi_mid;  // 0x20..0x3F
		logic               is_last;
	} item_t;

	function automatic logic in_rng(logic [CP_BITS-1:0] c, int lo, int hi);
		return (c >= CP_BITS'(lo)) && (c <= CP_BITS'(hi));
	endfunction

	function automatic logic is_zero_tab(logic [CP_BITS-1:0] c);
		logic r;
		r = (c == '0) || in_rng(c,'hAD,'hAD) || in_rng(c,'h300,'h36F) ||
			in_rng(c,'h483,'h486) || in_rng(c,'h488,'h489) || in_rng(c,'h591,'h5B9) ||
			in_rng(c,'h5BB,'h5BD) || in_rng(c,'h5BF,'h5BF) || in_rng(c,'h5C1,'h5C2) ||
			in_rng(c,'h5C4,'h5C5) || in_rng(c,'h5C7,'h5C7) || in_rng(c,'h600,'h603) ||
			in_rng(c,'h610,'h615) || in_rng(c,'h64B,'h65E) || in_rng(c,'h670,'h670) ||
			in_rng(c,'h6D6,'h6E4) || in_rng(c,'h6E7,'h6E8) || in_rng(c,'h6EA,'h6ED) ||
			in_rng(c,'h70F,'h70F) || in_rng(c,'h711,'h711) || in_rng(c,'h730,'h74A) ||
			in_rng(c,'h7A6,'h7B0) || in_rng(c,'h901,'h903) || in_rng(c,'h93C,'h93C) ||
			in_rng(c,'h93E,'h94D) || in_rng(c,'h951,'h954) || in_rng(c,'h962,'h963) ||
			in_rng(c,'h981,'h983) || in_rng(c,'h9BC,'h9BC) || in_rng(c,'h9BE,'h9C4) ||
			in_rng(c,'h9C7,'h9C8) || in_rng(c,'h9CB,'h9CD) || in_rng(c,'h9D7,'h9D7) ||
			in_rng(c,'h9E2,'h9E3) || in_rng(c,'hA01,'hA03) || in_rng(c,'hA3C,'hA3C) ||
			in_rng(c,'hA3E,'hA42) || in_rng(c,'hA47,'hA48) || in_rng(c,'hA4B,'hA4D) ||
			in_rng(c,'hA70,'hA71) || in_rng(c,'hA81,'hA83) || in_rng(c,'hABC,'hABC) ||
			in_rng(c,'hABE,'hAC5) || in_rng(c,'hAC7,'hAC9) || in_rng(c,'hACB,'hACD) ||
			in_rng(c,'hAE2,'hAE3) || in_rng(c,'hB01,'hB03) || in_rng(c,'hB3C,'hB3C) ||
			in_rng(c,'hB3E,'hB43) || in_rng(c,'hB47,'hB48) || in_rng(c,'hB4B,'hB4D) ||
			in_rng(c,'hB56,'hB57) || in_rng(c,'hB82,'hB82) || in_rng(c,'hBBE,'hBC2) ||
			in_rng(c,'hBC6,'hBC8) || in_rng(c,'hBCA,'hBCD) || in_rng(c,'hBD7,'hBD7) ||
			in_rng(c,'hC01,'hC03) || in_rng(c,'hC3E,'hC44) || in_rng(c,'hC46,'hC48) ||
			in_rng(c,'hC4A,'hC4D) || in_rng(c,'hC55,'hC56) || in_rng(c,'hC82,'hC83) ||
			in_rng(c,'hCBC,'hCBC) || in_rng(c,'hCBE,'hCC4) || in_rng(c,'hCC6,'hCC8) ||
			in_rng(c,'hCCA,'hCCD) || in_rng(c,'hCD5,'hCD6) || in_rng(c,'hD02,'hD03) ||
			in_rng(c,'hD3E,'hD43) || in_rng(c,'hD46,'hD48) || in_rng(c,'hD4A,'hD4D) ||
			in_rng(c,'hD57,'hD57) || in_rng(c,'hD82,'hD83) || in_rng(c,'hDCA,'hDCA) ||
			in_rng(c,'hDCF,'hDD4) || in_rng(c,'hDD6,'hDD6) || in_rng(c,'hDD8,'hDDF) ||
			in_rng(c,'hDF2,'hDF3) || in_rng(c,'hE31,'hE31) || in_rng(c,'hE34,'hE3A) ||
			in_rng(c,'hE47,'hE4E) || in_rng(c,'hEB1,'hEB1) || in_rng(c,'hEB4,'hEB9) ||
			in_rng(c,'hEBB,'hEBC) || in_rng(c,'hEC8,'hECD) || in_rng(c,'hF18,'hF19) ||
			in_rng(c,'hF35,'hF35) || in_rng(c,'hF37,'hF37) || in_rng(c,'hF39,'hF39) ||
			in_rng(c,'hF3E,'hF3F) || in_rng(c,'hF71,'hF84) || in_rng(c,'hF86,'hF87) ||
			in_rng(c,'hF90,'hF97) || in_rng(c,'hF99,'hFBC) || in_rng(c,'hFC6,'hFC6) ||
			in_rng(c,'h102C,'h1032) || in_rng(c,'h1036,'h1039) ||
			in_rng(c,'h1056,'h1059) || in_rng(c,'h1160,'h11FF) ||
			in_rng(c,'h135F,'h135F) || in_rng(c,'h1712,'h1714) ||
			in_rng(c,'h1732,'h1734) || in_rng(c,'h1752,'h1753) ||
			in_rng(c,'h1772,'h1773) || in_rng(c,'h17B4,'h17D3) ||
			in_rng(c,'h17DD,'h17DD) || in_rng(c,'h180B,'h180D) ||
			in_rng(c,'h18A9,'h18A9) || in_rng(c,'h1920,'h192B) ||
			in_rng(c,'h1930,'h193B) || in_rng(c,'h19B0,'h19C0) ||
			in_rng(c,'h19C8,'h19C9) || in_rng(c,'h1A17,'h1A1B) ||
			in_rng(c,'h1DC0,'h1DC3) || in_rng(c,'h200B,'h200F) ||
			in_rng(c,'h2028,'h202E) || in_rng(c,'h2060,'h2063) ||
			in_rng(c,'h206A,'h206F) || in_rng(c,'h20D0,'h20EB) ||
			in_rng(c,'h302A,'h302F) || in_rng(c,'h3099,'h309A) ||
			in_rng(c,'hA802,'hA802) || in_rng(c,'hA806,'hA806) ||
			in_rng(c,'hA80B,'hA80B) || in_rng(c,'hA823,'hA827) ||
			in_rng(c,'hD7B0,'hD7FF) || in_rng(c,'hFB1E,'hFB1E) ||
			in_rng(c,'hFE00,'hFE0F) || in_rng(c,'hFE20,'hFE23) ||
			in_rng(c,'hFEFF,'hFEFF) || in_rng(c,'hFFF9,'hFFFB) ||
			in_rng(c,'h10A01,'h10A03) || in_rng(c,'h10A05,'h10A06) ||
			in_rng(c,'h10A0C,'h10A0F) || in_rng(c,'h10A38,'h10A3A) ||
			in_rng(c,'h10A3F,'h10A3F) || in_rng(c,'h1D165,'h1D169) ||
			in_rng(c,'h1D16D,'h1D182) || in_rng(c,'h1D185,'h1D18B) ||
			in_rng(c,'h1D1AA,'h1D1AD) || in_rng(c,'h1D242,'h1D244) ||
			in_rng(c,'hE0001,'hE0001) || in_rng(c,'hE0020,'hE007F) ||
			in_rng(c,'hE0100,'hE01EF);
		return r;
	endfunction

	function automatic logic is_wide_tab(logic [CP_BITS-1:0] c);
		logic r;
		r = in_rng(c,'h1100,'h1159) || in_rng(c,'h115F,'h115F) ||
			in_rng(c,'h2329,'h232A) || in_rng(c,'h2E80,'h2E99) ||
			in_rng(c,'h2E9B,'h2EF3) || in_rng(c,'h2F00,'h2FD5) ||
			in_rng(c,'h2FF0,'h2FFB) || in_rng(c,'h3000,'h3029) ||
			in_rng(c,'h3030,'h303E) || in_rng(c,'h3041,'h3096) ||
			in_rng(c,'h309B,'h30FF) || in_rng(c,'h3105,'h312C) ||
			in_rng(c,'h3131,'h318E) || in_rng(c,'h3190,'h31B7) ||
			in_rng(c,'h31C0,'h31CF) || in_rng(c,'h31F0,'h321E) ||
			in_rng(c,'h3220,'h3243) || in_rng(c,'h3250,'h32FE) ||
			in_rng(c,'h3300,'h4DB5) || in_rng(c,'h4E00,'h9FBB) ||
			in_rng(c,'hA000,'hA48C) || in_rng(c,'hA490,'hA4C6) ||
			in_rng(c,'hAC00,'hD7A3) || in_rng(c,'hF900,'hFA2D) ||
			in_rng(c,'hFA30,'hFA6A) || in_rng(c,'hFA70,'hFAD9) ||
			in_rng(c,'hFE10,'hFE19) || in_rng(c,'hFE30,'hFE52) ||
			in_rng(c,'hFE54,'hFE66) || in_rng(c,'hFE68,'hFE6B) ||
			in_rng(c,'hFF01,'hFF60) || in_rng(c,'hFFE0,'hFFE6) ||
			in_rng(c,'h20000,'h2FFFD) || in_rng(c,'h30000,'h3FFFD);
		return r;
	endfunction

	function automatic logic is_vs16_tab(logic [CP_BITS-1:0] c);
		logic r;
		r = in_rng(c,'h23,'h23) || in_rng(c,'h2A,'h2A) || in_rng(c,'h30,'h39) ||
			in_rng(c,'hA9,'hA9) || in_rng(c,'hAE,'hAE) || in_rng(c,'h203C,'h203C) ||
			in_rng(c,'h2049,'h2049) || in_rng(c,'h2122,'h2122) ||
			in_rng(c,'h2139,'h2139) || in_rng(c,'h2194,'h2199) ||
			in_rng(c,'h21A9,'h21AA) || in_rng(c,'h2328,'h2328) ||
			in_rng(c,'h23CF,'h23CF) || in_rng(c,'h23ED,'h23EF) ||
			in_rng(c,'h23F1,'h23F2) || in_rng(c,'h23F8,'h23FA) ||
			in_rng(c,'h24C2,'h24C2) || in_rng(c,'h25AA,'h25AB) ||
			in_rng(c,'h25B6,'h25B6) || in_rng(c,'h25C0,'h25C0) ||
			in_rng(c,'h25FB,'h25FC) || in_rng(c,'h2600,'h2604) ||
			in_rng(c,'h260E,'h260E) || in_rng(c,'h2611,'h2611) ||
			in_rng(c,'h2618,'h2618) || in_rng(c,'h261D,'h261D) ||
			in_rng(c,'h2620,'h2620) || in_rng(c,'h2622,'h2623) ||
			in_rng(c,'h2626,'h2626) || in_rng(c,'h262A,'h262A) ||
			in_rng(c,'h262E,'h262F) || in_rng(c,'h2638,'h263A) ||
			in_rng(c,'h2640,'h2640) || in_rng(c,'h2642,'h2642) ||
			in_rng(c,'h265F,'h2660) || in_rng(c,'h2663,'h2663) ||
			in_rng(c,'h2665,'h2666) || in_rng(c,'h2668,'h2668) ||
			in_rng(c,'h267B,'h267B) || in_rng(c,'h267E,'h267E) ||
			in_rng(c,'h2692,'h2692) || in_rng(c,'h2694,'h2697) ||
			in_rng(c,'h2699,'h2699) || in_rng(c,'h269B,'h269C) ||
			in_rng(c,'h26A0,'h26A0) || in_rng(c,'h26A7,'h26A7) ||
			in_rng(c,'h26B0,'h26B1) || in_rng(c,'h26C8,'h26C8) ||
			in_rng(c,'h26CF,'h26CF) || in_rng(c,'h26D1,'h26D1) ||
			in_rng(c,'h26D3,'h26D3) || in_rng(c,'h26E9,'h26E9) ||
			in_rng(c,'h26F0,'h26F1) || in_rng(c,'h26F4,'h26F4) ||
			in_rng(c,'h26F7,'h26F9) || in_rng(c,'h2702,'h2702) ||
			in_rng(c,'h2708,'h2709) || in_rng(c,'h270C,'h270D) ||
			in_rng(c,'h270F,'h270F) || in_rng(c,'h2712,'h2712) ||
			in_rng(c,'h2714,'h2714) || in_rng(c,'h2716,'h2716) ||
			in_rng(c,'h271D,'h271D) || in_rng(c,'h2721,'h2721) ||
			in_rng(c,'h2733,'h2734) || in_rng(c,'h2744,'h2744) ||
			in_rng(c,'h2747,'h2747) || in_rng(c,'h2763,'h2764) ||
			in_rng(c,'h27A1,'h27A1) || in_rng(c,'h2934,'h2935) ||
			in_rng(c,'h2B05,'h2B07) || in_rng(c,'h1F170,'h1F171) ||
			in_rng(c,'h1F17E,'h1F17F) || in_rng(c,'h1F321,'h1F321) ||
			in_rng(c,'h1F324,'h1F32C) || in_rng(c,'h1F336,'h1F336) ||
			in_rng(c,'h1F37D,'h1F37D) || in_rng(c,'h1F396,'h1F397) ||
			in_rng(c,'h1F399,'h1F39B) || in_rng(c,'h1F39E,'h1F39F) ||
			in_rng(c,'h1F3CB,'h1F3CE) || in_rng(c,'h1F3D4,'h1F3DF) ||
			in_rng(c,'h1F3F3,'h1F3F3) || in_rng(c,'h1F3F5,'h1F3F5) ||
			in_rng(c,'h1F3F7,'h1F3F7) || in_rng(c,'h1F43F,'h1F43F) ||
			in_rng(c,'h1F441,'h1F441) || in_rng(c,'h1F4FD,'h1F4FD) ||
			in_rng(c,'h1F549,'h1F54A) || in_rng(c,'h1F56F,'h1F570) ||
			in_rng(c,'h1F573,'h1F579) || in_rng(c,'h1F587,'h1F587) ||
			in_rng(c,'h1F58A,'h1F58D) || in_rng(c,'h1F590,'h1F590) ||
			in_rng(c,'h1F5A5,'h1F5A5) || in_rng(c,'h1F5A8,'h1F5A8) ||
			in_rng(c,'h1F5B1,'h1F5B2) || in_rng(c,'h1F5BC,'h1F5BC) ||
			in_rng(c,'h1F5C2,'h1F5C4) || in_rng(c,'h1F5D1,'h1F5D3) ||
			in_rng(c,'h1F5DC,'h1F5DE) || in_rng(c,'h1F5E1,'h1F5E1) ||
			in_rng(c,'h1F5E3,'h1F5E3) || in_rng(c,'h1F5E8,'h1F5E8) ||
			in_rng(c,'h1F5EF,'h1F5EF) || in_rng(c,'h1F5F3,'h1F5F3) ||
			in_rng(c,'h1F5FA,'h1F5FA) || in_rng(c,'h1F6CB,'h1F6CB) ||
			in_rng(c,'h1F6CD,'h1F6CF) || in_rng(c,'h1F6E0,'h1F6E5) ||
			in_rng(c,'h1F6E9,'h1F6E9) || in_rng(c,'h1F6F0,'h1F6F0) ||
			in_rng(c,'h1F6F3,'h1F6F3);
		return r;
	endfunction

endpackage

FILE: rtl/ttwc_front.sv
// ----------------------------------------------------------------------------
// ttwc_front
// Accepts code points, looks them up in the range tables and registers the
// classified request.
// ----------------------------------------------------------------------------
module ttwc_front import ttwc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CP_BITS-1:0] in_cp,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_ready,
	output item_t              out_item
);

	item_t cls;
	logic  valid_s1;

	// Width class of the incoming code point.
	always_comb begin
		cls.cp      = in_cp;
		cls.is_last = in_last;
		cls.vs16_ok = is_vs16_tab(in_cp);
		cls.esc_fin = in_rng(in_cp, 'h40, 'h5F);
		cls.csi_fin = in_rng(in_cp, 'h40, 'h7E);
		cls.csi_mid = in_rng(in_cp, 'h20, 'h3F);
		priority if (in_cp == CP_ZWJ) begin
			cls.kind = K_ZWJ;
		end else if (in_cp == CP_VS16) begin
			cls.kind = K_VS16;
		end else if (in_cp == CP_ESC) begin
			cls.kind = K_ESC;
		end else if (in_rng(in_cp, 'h20, 'h7E)) begin
			cls.kind = K_W1;
		end else if ((in_cp != '0 && in_cp < CP_BITS'('h20)) ||
				in_rng(in_cp, 'h7F, 'h9F) || is_zero_tab(in_cp)) begin
			cls.kind = K_W0;
		end else if (is_wide_tab(in_cp)) begin
			cls.kind = K_W2;
		end else begin
			cls.kind = K_W1;
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_item <= cls;
		end
	end

endmodule

FILE: rtl/ttwc_queue.sv
// ----------------------------------------------------------------------------
// ttwc_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module ttwc_queue import ttwc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  logic  rd_ready,
	output item_t rd_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t            mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             push, pop;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_item  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count overflow");

endmodule

FILE: rtl/ttwc_back.sv
// ----------------------------------------------------------------------------
// ttwc_back
// Runs the parse state machine, accumulates the width and registers the
// result at the end of each string.
// ----------------------------------------------------------------------------
module ttwc_back import ttwc_pkg::*; #(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  item_t               in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_BITS-1:0] out_width,
	output logic [1:0]          out_status
);

	typedef enum logic [1:0] {M_NORMAL, M_JOIN, M_ESC, M_CSI} mode_t;

	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

	mode_t               mode_q, mode_d;
	logic [CP_BITS-1:0]  last_cp_q, last_cp_d;
	logic                last_vs_q, last_vs_d;
	logic                lval_q, lval_d;
	logic [SUM_BITS-1:0] sum_q, sum_d;
	logic [1:0]          fault_q, fault_d;
	logic [1:0]          add_w;
	logic [SUM_BITS:0]   sum_ext;
	logic                take;

	assign in_ready = !out_valid || out_ready;
	assign take     = in_valid && in_ready;

	// Next state for one request.
	always_comb begin
		mode_d    = mode_q;
		last_cp_d = last_cp_q;
		last_vs_d = last_vs_q;
		lval_d    = lval_q;
		fault_d   = fault_q;
		add_w     = 2'd0;
		if (fault_q == ST_OK) begin
			unique case (mode_q)
				M_NORMAL: begin
					unique case (in_item.kind)
						K_ZWJ: mode_d = M_JOIN;
						K_ESC: mode_d = M_ESC;
						K_VS16: begin
							if (lval_q) begin
								add_w  = last_vs_q ? 2'd1 : 2'd0;
								lval_d = 1'b0;
							end
						end
						K_W0: add_w = 2'd0;
						K_W1, K_W2: begin
							add_w     = (in_item.kind == K_W2) ? 2'd2 : 2'd1;
							last_cp_d = in_item.cp;
							last_vs_d = in_item.vs16_ok;
							lval_d    = 1'b1;
						end
						default: add_w = 2'd0;
					endcase
				end
				M_JOIN: mode_d = M_NORMAL;
				M_ESC: begin
					priority if (in_item.cp == CP_LBRACKET) mode_d = M_CSI;
					else if (in_item.esc_fin) mode_d = M_NORMAL;
					else fault_d = ST_BAD_ESC;
				end
				M_CSI: begin
					priority if (in_item.csi_fin) mode_d = M_NORMAL;
					else if (!in_item.csi_mid) fault_d = ST_BAD_CSI;
				end
				default: mode_d = M_NORMAL;
			endcase
		end
		sum_ext = {1'b0, sum_q} + (SUM_BITS+1)'(add_w);
		sum_d   = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
	end

	// State and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_NORMAL;
			last_cp_q  <= '0;
			last_vs_q  <= 1'b0;
			lval_q     <= 1'b0;
			sum_q      <= '0;
			fault_q    <= ST_OK;
			out_valid  <= 1'b0;
			out_width  <= '0;
			out_status <= ST_OK;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (take) begin
				if (in_item.is_last) begin
					out_valid  <= 1'b1;
					out_status <= fault_d;
					if (fault_d != ST_OK) begin
						out_width <= '0;
					end else if (SUM_BITS > OUT_BITS &&
							(sum_d >> OUT_BITS) != '0) begin
						out_width <= '1;
					end else begin
						out_width <= OUT_BITS'(sum_d);
					end
					mode_q    <= M_NORMAL;
					last_cp_q <= '0;
					last_vs_q <= 1'b0;
					lval_q    <= 1'b0;
					sum_q     <= '0;
					fault_q   <= ST_OK;
				end else begin
					mode_q    <= mode_d;
					last_cp_q <= last_cp_d;
					last_vs_q <= last_vs_d;
					lval_q    <= lval_d;
					sum_q     <= sum_d;
					fault_q   <= fault_d;
				end
			end
		end
	end

	// A fault freezes the parse state until the string ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fault_q != ST_OK && take && !in_item.is_last) |=> $stable(mode_q))
		else $error("mode moved after fault");
	// A result with a fault carries zero width.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status != ST_OK) |-> out_width == '0)
		else $error("faulted result has width");
	// The accumulator never shrinks inside a string.
	assert property (@(posedge clk) disable iff (!arst_n)
		($past(take) && !$past(in_item.is_last)) |-> sum_q >= $past(sum_q))
		else $error("sum decreased");

endmodule

FILE: rtl/terminal_text_width_counter.sv
// ----------------------------------------------------------------------------
// terminal_text_width_counter
// Terminal column width of a code point string.
// ----------------------------------------------------------------------------
// Usage: send one UTF-32 code point per request on s_axis (tdata bits 20:0),
// with s_axis_tlast high on the final code point of a string. One result per
// string appears on m_axis: tdata bits 23:0 total width, bits 25:24 status
// (0 ok, 1 bad escape, 2 bad CSI; width is zero on error).
// Throughput is one code point per cycle while no result waits on m_axis. When
// nothing stalls, the last code point is written into the table lookup
// register, then the request queue, then the output register, which raises
// m_axis_tvalid. While a result waits on m_axis the state machine
// holds, so the queue fills, then the lookup stage, and then s_axis_tready
// falls; nothing is lost. Reset clears the parser, the accumulator and the
// queue; the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
module terminal_text_width_counter import ttwc_pkg::*; #(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [20:0] code_point, zero fill
	input  logic        s_axis_tlast,   // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [23:0] total_width, [25:24] status
);

	logic                f_valid, f_ready, q_valid, q_ready;
	item_t               f_item, q_item;
	logic [OUT_BITS-1:0] r_width;
	logic [1:0]          r_status;

	ttwc_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cp(s_axis_tdata[CP_BITS-1:0]), .in_last(s_axis_tlast),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	ttwc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	ttwc_back #(.SUM_BITS(SUM_BITS)) u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_width(r_width), .out_status(r_status)
	);

	assign m_axis_tdata = {6'd0, r_status, r_width};

endmodule
